// ===== sv/ffsc_pkg.sv =====
package ffsc_pkg;

  // Width of one serial byte on every channel.
  localparam int BYTE_W = 8;

  // Default frame geometry.
  localparam int FRAME_LENGTH_DEF = 32;
  localparam int HEADER_SIZE_DEF  = 6;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== sv/ffsc_ram.sv =====
module ffsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/fixed_frame_sync_checksum_core.sv =====
// Channel   Dir  Signals                       Beat carries
// s_*       in   s_tvalid s_tready s_tdata     rx_byte
// m_*       out  m_tvalid m_tready m_tdata     payload_byte, tlast = payload_last
//                m_tlast
// cfg_*     in   cfg_valid cfg_ready cfg_data  start_byte
//
// Received bytes are accepted back to back while hunting or collecting a frame.
// After a frame passes its checksum the payload is read back from the frame memory
// through its single read port, one read in flight at a time; input stalls meanwhile.
// Reset returns the block to hunting with start_byte 0; the frame memory is not cleared.
// A stalled last payload beat is held while hunting for the next frame continues.
module fixed_frame_sync_checksum_core #(
  parameter int FRAME_LENGTH = ffsc_pkg::FRAME_LENGTH_DEF,
  parameter int HEADER_SIZE  = ffsc_pkg::HEADER_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Received bytes. tdata: [7:0] rx_byte.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  ffsc_pkg::byte_t      s_tdata,
  // Payload bytes. tdata: [7:0] payload_byte.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output ffsc_pkg::byte_t      m_tdata,
  output logic                 m_tlast,
  // Start byte register. data: [7:0] start_byte.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  ffsc_pkg::byte_t      cfg_data
);

  import ffsc_pkg::*;

  localparam int AW          = $clog2(FRAME_LENGTH);
  localparam bit HAS_PAYLOAD = HEADER_SIZE < FRAME_LENGTH - 1;

  localparam logic [AW-1:0] POS_LAST   = AW'(FRAME_LENGTH - 1);
  localparam logic [AW-1:0] PAY_FIRST  = AW'(HEADER_SIZE);
  localparam logic [AW-1:0] PAY_LAST   = AW'(FRAME_LENGTH - 2);

  localparam logic [1:0] ST_HUNT  = 2'd0;
  localparam logic [1:0] ST_FRAME = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]    state;
  byte_t         start_byte;
  logic [AW-1:0] byte_position;
  byte_t         running_sum;
  logic [AW-1:0] rd_addr;
  logic          rd_pend;
  logic          rd_last_pend;

  logic          s_fire;
  logic          m_fire;
  logic          at_check;
  logic          sum_ok;
  logic          rd_issue;
  logic          wr_en;
  byte_t         rd_data;

  assign cfg_ready = 1'b1;
  assign s_tready  = state inside {ST_HUNT, ST_FRAME};
  assign s_fire    = s_tvalid && s_tready;
  assign m_fire    = m_tvalid && m_tready;
  assign at_check  = (state == ST_FRAME) && (byte_position == POS_LAST);
  assign sum_ok    = s_tdata == running_sum;

  // Frame bytes go to memory; the checksum byte itself is never read back.
  assign wr_en = s_fire && !at_check &&
                 ((state == ST_FRAME) || (s_tdata == start_byte));

  // A read is issued only when the output register is sure to be free on return.
  assign rd_issue = (state == ST_EMIT) && !rd_pend && (!m_tvalid || m_fire);

  ffsc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_LENGTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ((state == ST_FRAME) ? byte_position : '0),
    .wr_data (s_tdata),
    .rd_en   (rd_issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Start byte register.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= '0;
    end else if (cfg_valid && cfg_ready) begin
      start_byte <= cfg_data;
    end
  end

  // Hunting, frame collection and payload read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_HUNT;
      byte_position <= '0;
      running_sum   <= '0;
      rd_addr       <= '0;
      rd_pend       <= 1'b0;
      rd_last_pend  <= 1'b0;
    end else begin
      case (state)
        ST_HUNT: begin
          if (s_fire && (s_tdata == start_byte)) begin
            state         <= ST_FRAME;
            byte_position <= AW'(1);
            running_sum   <= s_tdata;
          end
        end
        ST_FRAME: begin
          if (s_fire) begin
            if (at_check) begin
              byte_position <= '0;
              running_sum   <= '0;
              rd_addr       <= PAY_FIRST;
              state         <= (sum_ok && HAS_PAYLOAD) ? ST_EMIT : ST_HUNT;
            end else begin
              byte_position <= byte_position + AW'(1);
              running_sum   <= running_sum + s_tdata;
            end
          end
        end
        ST_EMIT: begin
          rd_pend <= rd_issue;
          if (rd_issue) begin
            rd_last_pend <= rd_addr == PAY_LAST;
            rd_addr      <= rd_addr + AW'(1);
          end
          if (rd_pend && rd_last_pend) begin
            state <= ST_HUNT;
          end
        end
        default: begin
          state <= ST_HUNT;
        end
      endcase
    end
  end

  // Output register, loaded from the memory read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rd_pend) begin
      m_tvalid <= 1'b1;
    end else if (m_fire) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      m_tdata <= rd_data;
      m_tlast <= rd_last_pend;
    end
  end

`ifndef SYNTHESIS
  // Read data must never land on a beat that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !m_tvalid)
    else $error("payload read returned while output register full");

  // Reads happen only while reading back a payload.
  a_read_in_emit: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == ST_EMIT))
    else $error("memory read outside payload read-back");

  // A failed checksum sends the block straight back to hunting.
  a_bad_sum_drop: assert property (@(posedge clk) disable iff (rst)
    (s_fire && at_check && !sum_ok) |=> (state == ST_HUNT))
    else $error("frame with bad checksum not dropped");

  // The frame position stays inside the frame.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_LAST)
    else $error("frame position out of range");

  // The final payload beat always ends read-back.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (rd_pend && rd_last_pend) |=> (state == ST_HUNT) && m_tvalid && m_tlast)
    else $error("last payload beat did not end read-back");
`endif

endmodule
